[design/fcse_pkg.sv]
// ----------------------------------------------------------------------------
// fcse_pkg
// shared types, constants and the cordic arctangent table of the envelope core
// ----------------------------------------------------------------------------
package fcse_pkg;

  localparam int TimeWidthDef    = 32;
  localparam int CordicStagesDef = 16;

  localparam int XW = 34;
  localparam int ZW = 33;

  localparam logic signed [XW-1:0] CordicInit = 34'sd652032874;

  localparam logic [16:0] QOne = 17'd65536;

  typedef enum logic [2:0] {
    RegBefore = 3'd0,
    RegRise   = 3'd1,
    RegFlat   = 3'd2,
    RegFall   = 3'd3,
    RegAfter  = 3'd4
  } region_e;

  typedef struct packed {
    logic    valid;
    region_e region;
  } meta_t;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 flip;
  } rot_t;

  function automatic logic [31:0] atan_turns(input int unsigned idx);
    logic [31:0] r;
    case (idx)
      0:  r = 32'd536870912;
      1:  r = 32'd316933406;
      2:  r = 32'd167458907;
      3:  r = 32'd85004756;
      4:  r = 32'd42667331;
      5:  r = 32'd21354465;
      6:  r = 32'd10679838;
      7:  r = 32'd5340245;
      8:  r = 32'd2670163;
      9:  r = 32'd1335087;
      10: r = 32'd667544;
      11: r = 32'd333772;
      12: r = 32'd166886;
      13: r = 32'd83443;
      14: r = 32'd41722;
      15: r = 32'd20861;
      16: r = 32'd10430;
      17: r = 32'd5215;
      18: r = 32'd2608;
      19: r = 32'd1304;
      20: r = 32'd652;
      21: r = 32'd326;
      22: r = 32'd163;
      23: r = 32'd81;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

[design/fcse_front.sv]
// ----------------------------------------------------------------------------
// fcse_front
// time capture, region decode, ramp offset and angle product
// ----------------------------------------------------------------------------
module fcse_front import fcse_pkg::*; #(
  parameter int TIME_WIDTH = TimeWidthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        in_valid_i,
  input  logic [31:0] sample_time_i,
  input  logic [19:0] ramp_ticks_i,
  input  logic [23:0] end_ticks_i,
  input  logic [30:0] phase_step_i,
  output meta_t       meta_o,
  output rot_t        rot_o
);

  localparam int CW = ((TIME_WIDTH > 25) ? TIME_WIDTH : 25) + 1;

  logic [47:0]                 time_ext;
  logic signed [TIME_WIDTH-1:0] t_d, t_q;
  logic                        v1_q, v2_q, v3_q;
  region_e                     reg2_d, reg2_q, reg3_q;
  logic [19:0]                 tau_d, tau_q;
  logic [31:0]                 angle_d, angle_q, angle_adj;
  logic signed [CW-1:0]        tc, rc, ec, erc, fall_off;
  logic [50:0]                 prod;
  logic                        flip;

  assign time_ext = {{16{sample_time_i[31]}}, sample_time_i};
  assign t_d      = time_ext[TIME_WIDTH-1:0];

  always_comb begin
    tc       = CW'(t_q);
    rc       = $signed({{(CW-20){1'b0}}, ramp_ticks_i});
    ec       = $signed({{(CW-24){1'b0}}, end_ticks_i});
    erc      = ec - rc;
    fall_off = tc - erc;
    tau_d    = 20'd0;
    if (tc < 0) begin
      reg2_d = RegBefore;
    end else if (tc < rc) begin
      reg2_d = RegRise;
      tau_d  = tc[19:0];
    end else if (tc < erc) begin
      reg2_d = RegFlat;
    end else if (tc < ec) begin
      reg2_d = RegFall;
      tau_d  = fall_off[19:0];
    end else begin
      reg2_d = RegAfter;
    end
  end

  assign prod    = {31'd0, tau_q} * {20'd0, phase_step_i};
  assign angle_d = prod[31:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      reg2_q <= RegBefore;
      reg3_q <= RegBefore;
    end else if (en_i) begin
      v1_q   <= in_valid_i;
      v2_q   <= v1_q;
      v3_q   <= v2_q;
      reg2_q <= reg2_d;
      reg3_q <= reg2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t_q     <= t_d;
      tau_q   <= tau_d;
      angle_q <= angle_d;
    end
  end

  // second and third quadrants rotate by half a turn
  assign flip      = (angle_q[31:30] == 2'b01) || (angle_q[31:30] == 2'b10);
  assign angle_adj = flip ? angle_q + 32'h8000_0000 : angle_q;

  assign meta_o.valid  = v3_q;
  assign meta_o.region = reg3_q;
  assign rot_o.x       = CordicInit;
  assign rot_o.y       = '0;
  assign rot_o.z       = $signed({angle_adj[31], angle_adj});
  assign rot_o.flip    = flip;

endmodule

[design/fcse_cordic_stage.sv]
// ----------------------------------------------------------------------------
// fcse_cordic_stage
// one registered micro-rotation of the cordic
// ----------------------------------------------------------------------------
module fcse_cordic_stage import fcse_pkg::*; #(
  parameter int Idx = 0
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  meta_t meta_i,
  input  rot_t  rot_i,
  output meta_t meta_o,
  output rot_t  rot_o
);

  logic signed [XW-1:0] dx, dy;
  logic signed [ZW-1:0] at;
  rot_t                 rot_d, rot_q;
  meta_t                meta_q;

  assign dx = rot_i.y >>> Idx;
  assign dy = rot_i.x >>> Idx;
  assign at = $signed({1'b0, atan_turns(Idx)});

  always_comb begin
    rot_d.flip = rot_i.flip;
    if (rot_i.z >= 0) begin
      rot_d.x = rot_i.x - dx;
      rot_d.y = rot_i.y + dy;
      rot_d.z = rot_i.z - at;
    end else begin
      rot_d.x = rot_i.x + dx;
      rot_d.y = rot_i.y - dy;
      rot_d.z = rot_i.z + at;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      meta_q <= '{valid: 1'b0, region: RegBefore};
    end else if (en_i) begin
      meta_q <= meta_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rot_q <= rot_d;
    end
  end

  assign meta_o = meta_q;
  assign rot_o  = rot_q;

endmodule

[design/fcse_post.sv]
// ----------------------------------------------------------------------------
// fcse_post
// sin and cos rounding, squares, slope product and output register
// ----------------------------------------------------------------------------
module fcse_post import fcse_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  meta_t       meta_i,
  input  rot_t        rot_i,
  input  logic [31:0] slope_gain_i,
  output logic        valid_o,
  output logic [16:0] envelope_o,
  output logic [31:0] field_value_o,
  output logic [2:0]  region_o
);

  meta_t                m1_q, m2_q, m3_q, m4_q, m5_q;
  logic signed [XW:0]   ys, xs, sr, cr;
  logic signed [17:0]   s_d, c_d, s_q, c_q;
  logic signed [35:0]   sq_q, sc_q;
  logic signed [36:0]   sq_r, sc_r;
  logic signed [17:0]   s2_d, s2_q;
  logic [16:0]          sqv, env_d, env3_q, env4_q, env_q;
  logic signed [50:0]   prod_q;
  logic signed [51:0]   pr, pf;
  logic signed [31:0]   fld_d, fld_q;

  function automatic logic signed [17:0] clamp_one(input logic signed [XW:0] v);
    logic signed [17:0] r;
    if (v > $signed((XW+1)'(65536))) begin
      r = 18'sd65536;
    end else if (v < -$signed((XW+1)'(65536))) begin
      r = -18'sd65536;
    end else begin
      r = v[17:0];
    end
    return r;
  endfunction

  // stage one: undo the half-turn and round to q16
  always_comb begin
    ys  = rot_i.flip ? -(XW+1)'(rot_i.y) : (XW+1)'(rot_i.y);
    xs  = rot_i.flip ? -(XW+1)'(rot_i.x) : (XW+1)'(rot_i.x);
    sr  = (ys + (XW+1)'(8192)) >>> 14;
    cr  = (xs + (XW+1)'(8192)) >>> 14;
    s_d = clamp_one(sr);
    c_d = clamp_one(cr);
  end

  // stage three: square and double angle, envelope select
  always_comb begin
    sq_r = (37'(sq_q) + 37'sd32768) >>> 16;
    sc_r = ((37'(sc_q) <<< 1) + 37'sd32768) >>> 16;
    if (sq_r > 37'sd65536) begin
      sqv = QOne;
    end else if (sq_r < 0) begin
      sqv = 17'd0;
    end else begin
      sqv = sq_r[16:0];
    end
    if (sc_r > 37'sd65536) begin
      s2_d = 18'sd65536;
    end else if (sc_r < -37'sd65536) begin
      s2_d = -18'sd65536;
    end else begin
      s2_d = sc_r[17:0];
    end
    case (m2_q.region)
      RegRise: env_d = sqv;
      RegFall: env_d = QOne - sqv;
      RegFlat: env_d = QOne;
      default: env_d = 17'd0;
    endcase
  end

  // stage five: round, sign and saturate
  always_comb begin
    pr = (52'(prod_q) + 52'sd32768) >>> 16;
    case (m4_q.region)
      RegRise: pf = -pr;
      RegFall: pf = pr;
      default: pf = '0;
    endcase
    if (pf > 52'sd2147483647) begin
      fld_d = 32'sh7FFF_FFFF;
    end else if (pf < -52'sd2147483648) begin
      fld_d = 32'sh8000_0000;
    end else begin
      fld_d = pf[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_q <= '{valid: 1'b0, region: RegBefore};
      m2_q <= '{valid: 1'b0, region: RegBefore};
      m3_q <= '{valid: 1'b0, region: RegBefore};
      m4_q <= '{valid: 1'b0, region: RegBefore};
      m5_q <= '{valid: 1'b0, region: RegBefore};
    end else if (en_i) begin
      m1_q <= meta_i;
      m2_q <= m1_q;
      m3_q <= m2_q;
      m4_q <= m3_q;
      m5_q <= m4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s_q    <= s_d;
      c_q    <= c_d;
      sq_q   <= 36'(s_q) * 36'(s_q);
      sc_q   <= 36'(s_q) * 36'(c_q);
      s2_q   <= s2_d;
      env3_q <= env_d;
      prod_q <= 51'($signed({1'b0, slope_gain_i})) * 51'(s2_q);
      env4_q <= env3_q;
      env_q  <= env4_q;
      fld_q  <= fld_d;
    end
  end

  assign valid_o       = m5_q.valid;
  assign envelope_o    = env_q;
  assign field_value_o = fld_q;
  assign region_o      = m5_q.region;

endmodule

[design/flat_top_sin2_ramp_envelope_core.sv]
// ----------------------------------------------------------------------------
// flat_top_sin2_ramp_envelope_core
// flat-top envelope with sin squared ramps and its negated slope
// ----------------------------------------------------------------------------
// Takes one time word per clock while the pipeline advances and returns one
// result word per word, in order, via front registers (time capture, region
// decode, angle product), a register in each cordic stage and post registers
// (rounding, squaring, slope product, output). All advance, and in_ready_o is
// high, when the output register is empty or taken. Registers must be written
// via cfg port only while no word is in flight; the block does not enforce it.
module flat_top_sin2_ramp_envelope_core import fcse_pkg::*; #(
  parameter int TIME_WIDTH    = TimeWidthDef,
  parameter int CORDIC_STAGES = CordicStagesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] sample_time_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [16:0] envelope_o,
  output logic [31:0] field_value_o,
  output logic [2:0]  region_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  localparam logic [7:0] CfgRamp  = 8'd0;
  localparam logic [7:0] CfgEnd   = 8'd1;
  localparam logic [7:0] CfgPhase = 8'd2;
  localparam logic [7:0] CfgGain  = 8'd3;

  logic        en;
  logic [19:0] ramp_q;
  logic [23:0] end_q;
  logic [30:0] phase_q;
  logic [31:0] gain_q;
  meta_t       meta [CORDIC_STAGES+1];
  rot_t        rot  [CORDIC_STAGES+1];

  assign en          = !out_valid_o || out_ready_i;
  assign in_ready_o  = en;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ramp_q  <= 20'd1024;
      end_q   <= 24'd4096;
      phase_q <= 31'd1048576;
      gain_q  <= 32'd101;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgRamp:  ramp_q  <= cfg_data_i[19:0];
        CfgEnd:   end_q   <= cfg_data_i[23:0];
        CfgPhase: phase_q <= cfg_data_i[30:0];
        CfgGain:  gain_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  fcse_front #(.TIME_WIDTH(TIME_WIDTH)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .in_valid_i   (in_valid_i),
    .sample_time_i(sample_time_i),
    .ramp_ticks_i (ramp_q),
    .end_ticks_i  (end_q),
    .phase_step_i (phase_q),
    .meta_o       (meta[0]),
    .rot_o        (rot[0])
  );

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
    fcse_cordic_stage #(.Idx(i)) u_stage (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .en_i  (en),
      .meta_i(meta[i]),
      .rot_i (rot[i]),
      .meta_o(meta[i+1]),
      .rot_o (rot[i+1])
    );
  end

  fcse_post u_post (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .meta_i       (meta[CORDIC_STAGES]),
    .rot_i        (rot[CORDIC_STAGES]),
    .slope_gain_i (gain_q),
    .valid_o      (out_valid_o),
    .envelope_o   (envelope_o),
    .field_value_o(field_value_o),
    .region_o     (region_o)
  );

endmodule

[design/fcse_checker.sv]
// ----------------------------------------------------------------------------
// fcse_checker
// port-level checks of the envelope core
// ----------------------------------------------------------------------------
module fcse_checker import fcse_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [16:0] envelope_o,
  input logic [31:0] field_value_o,
  input logic [2:0]  region_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(envelope_o)
      && $stable(field_value_o) && $stable(region_o))
    else $error("result word dropped or changed under stall");

  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_o)
    else $error("input stalled with output free");

  a_flat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && region_o == RegFlat |-> envelope_o == QOne && field_value_o == '0)
    else $error("flat top wrong");

  a_outside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (region_o == RegBefore || region_o == RegAfter)
      |-> envelope_o == '0 && field_value_o == '0)
    else $error("outside pulse not zero");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> envelope_o <= QOne && region_o <= RegAfter)
    else $error("result out of range");

endmodule

bind flat_top_sin2_ramp_envelope_core fcse_checker u_fcse_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .envelope_o   (envelope_o),
  .field_value_o(field_value_o),
  .region_o     (region_o)
);
